### hdl/tfmq_pkg.sv
`default_nettype none

package tfmq_pkg;

	// Default number of cells in the queue.
	localparam int QUEUE_DEPTH_DEF = 16;

	// Operation codes of an input transaction.
	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_TAG  = 2'd2
	} op_t;

	// Status codes of a result transaction.
	typedef enum logic [1:0] {
		ST_PUSHED    = 2'd0,
		ST_REMOVED   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// States of the top-level sequencer.
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// One queue entry.
	typedef struct packed {
		logic        [31:0] handle;
		logic        [30:0] size;
		logic signed [31:0] tag;
	} entry_t;

	// Control broadcast to every cell during the execute cycle.
	typedef struct packed {
		logic exec;
		logic push;
		logic pop_head;
		logic pop_tag;
	} ctl_t;

endpackage

`default_nettype wire

### hdl/tfmq_cell.sv
`default_nettype none

module tfmq_cell import tfmq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cap,
	input  logic signed [31:0] cmp_tag,
	input  ctl_t               ctl,
	input  entry_t             push_ent,
	input  logic               prev_occ,
	input  logic               prev_pfx,
	input  logic               nxt_occ,
	input  entry_t             nxt_ent,
	input  entry_t             rem_in,
	output logic               occ,
	output logic               pfx,
	output entry_t             ent,
	output entry_t             rem_out
);

	logic   occ_q;
	logic   hit_q;
	entry_t ent_q;
	logic   sel;
	logic   first;
	logic   push_here;

	// This cell is a removal candidate: any occupied cell for a plain pop, a tag hit otherwise.
	always_comb begin
		sel       = ctl.exec & ((ctl.pop_head & occ_q) | (ctl.pop_tag & hit_q));
		pfx       = prev_pfx | sel;
		first     = sel & ~prev_pfx;
		push_here = ctl.exec & ctl.push & ~occ_q & prev_occ;
		rem_out   = first ? ent_q : rem_in;
		occ       = occ_q;
		ent       = ent_q;
	end

	// The tag compare is registered when the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cap) begin
			hit_q <= occ_q && (ent_q.tag == cmp_tag);
		end
	end

	// Occupancy: cells at or after the removed one take over their neighbour.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (pfx) begin
			occ_q <= nxt_occ;
		end else if (push_here) begin
			occ_q <= 1'b1;
		end
	end

	// Entry payload follows the same shift and push rules.
	always_ff @(posedge clk) begin
		if (pfx) begin
			ent_q <= nxt_ent;
		end else if (push_here) begin
			ent_q <= push_ent;
		end
	end

endmodule

`default_nettype wire

### hdl/tagged_fifo_match_queue_top.sv
// The edge that takes a transaction moves the sequencer to S_EXEC, and done is registered
// from that execute state.
// Busy refuses a new transaction during execution; the execute cycle carries the first-match
// prefix along the cell chain and the shift of every cell behind the removed entry.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties the queue at once by clearing every cell's occupancy bit.
`default_nettype none

module tagged_fifo_match_queue_top import tfmq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [31:0]        data_handle,
	input  logic [30:0]        item_size,
	input  logic signed [31:0] match_tag,
	output logic               done,
	output logic [1:0]         status,
	output logic [31:0]        out_handle,
	output logic [30:0]        out_size,
	output logic signed [31:0] out_tag
);

	state_t     state_q;
	state_t     state_d;
	logic       cap;
	logic [1:0] op_q;
	entry_t     push_ent_q;
	ctl_t       ctl;
	logic       found;
	logic       full;
	status_t    status_d;
	logic       done_q;
	status_t    status_q;
	entry_t     out_ent_q;

	logic   occ_w [QUEUE_DEPTH];
	logic   pfx_w [QUEUE_DEPTH];
	entry_t ent_w [QUEUE_DEPTH];
	entry_t rem_w [QUEUE_DEPTH + 1];

	assign cap = start & ~busy;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and decoded control.
	always_comb begin
		state_d      = state_q;
		busy         = 1'b0;
		ctl          = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				busy         = 1'b1;
				ctl.exec     = 1'b1;
				ctl.push     = (op_q == OP_PUSH);
				ctl.pop_head = (op_q == OP_POP);
				ctl.pop_tag  = (op_q == OP_TAG);
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Command register, loaded when a transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_PUSH;
		end else if (cap) begin
			op_q <= operation;
		end
	end

	always_ff @(posedge clk) begin
		if (cap) begin
			push_ent_q.handle <= data_handle;
			push_ent_q.size   <= item_size;
			push_ent_q.tag    <= match_tag;
		end
	end

	// The row of cells; the head sits in cell zero.
	assign rem_w[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   prev_occ;
		logic   prev_pfx;
		logic   nxt_occ;
		entry_t nxt_ent;

		if (i == 0) begin : g_head
			assign prev_occ = 1'b1;
			assign prev_pfx = 1'b0;
		end else begin : g_body
			assign prev_occ = occ_w[i - 1];
			assign prev_pfx = pfx_w[i - 1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign nxt_occ = 1'b0;
			assign nxt_ent = '0;
		end else begin : g_inner
			assign nxt_occ = occ_w[i + 1];
			assign nxt_ent = ent_w[i + 1];
		end

		tfmq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cap      (cap),
			.cmp_tag  (match_tag),
			.ctl      (ctl),
			.push_ent (push_ent_q),
			.prev_occ (prev_occ),
			.prev_pfx (prev_pfx),
			.nxt_occ  (nxt_occ),
			.nxt_ent  (nxt_ent),
			.rem_in   (rem_w[i]),
			.occ      (occ_w[i]),
			.pfx      (pfx_w[i]),
			.ent      (ent_w[i]),
			.rem_out  (rem_w[i + 1])
		);
	end

	assign found = pfx_w[QUEUE_DEPTH - 1];
	assign full  = occ_w[QUEUE_DEPTH - 1];

	// Status of the transaction in execution.
	always_comb begin
		case (op_q)
			OP_PUSH: status_d = full ? ST_FULL : ST_PUSHED;
			OP_POP,
			OP_TAG:  status_d = found ? ST_REMOVED : ST_NOT_FOUND;
			default: status_d = ST_NOT_FOUND;
		endcase
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.exec;
		end
	end

	// Result payload; the removal chain yields zero when nothing is removed.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q  <= status_d;
			out_ent_q <= rem_w[QUEUE_DEPTH];
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign out_handle = out_ent_q.handle;
	assign out_size   = out_ent_q.size;
	assign out_tag    = out_ent_q.tag;

endmodule

`default_nettype wire

### hdl/tfmq_checker.sv
`default_nettype none

module tfmq_props import tfmq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [1:0]         status,
	input logic [31:0]        out_handle,
	input logic [30:0]        out_size,
	input logic signed [31:0] out_tag
);

	// A taken transaction makes the block busy for the next cycle.
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a transaction was taken");

	// Execution lasts a single cycle.
	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// Every execution cycle is followed by a result strobe.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("result strobe missing after execution");

	// A strobe never appears without a preceding execution cycle.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction");

	// Results other than a removal carry zero entry fields.
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_REMOVED) |->
			(out_handle == '0) && (out_size == '0) && (out_tag == '0))
		else $error("non-zero entry fields on a result without removal");

endmodule

bind tagged_fifo_match_queue_top tfmq_props u_tfmq_props (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.out_handle (out_handle),
	.out_size   (out_size),
	.out_tag    (out_tag)
);

`default_nettype wire

### sim/tfmq_checker.sv
`default_nettype none

module tfmq_checker import tfmq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         operation,
	input  logic [31:0]        data_handle,
	input  logic [30:0]        item_size,
	input  logic signed [31:0] match_tag,
	input  logic               done,
	input  logic [1:0]         status,
	input  logic [31:0]        out_handle,
	input  logic [30:0]        out_size,
	input  logic signed [31:0] out_tag,
	output int                 mismatches,
	output int                 outstanding
);

	// What one result transaction carries.
	typedef struct packed {
		status_t            status;
		logic        [31:0] handle;
		logic        [30:0] size;
		logic signed [31:0] tag;
	} removal_t;

	// Shadow copy of the queue, head in cell 0.
	entry_t   shadow_cells [QUEUE_DEPTH_DEF];
	int       shadow_fill = 0;
	removal_t awaited_results [$];
	int       error_tally = 0;

	initial mismatches = 0;
	initial outstanding = 0;

	// Applies one transaction to the shadow queue and returns the result it should give.
	function automatic removal_t apply_to_shadow(input logic [1:0] op, input entry_t item);
		removal_t res;
		int       pos;
		int       i;
		res = '0;
		res.status = ST_NOT_FOUND;
		pos = -1;
		case (op)
			OP_PUSH: begin
				if (shadow_fill >= QUEUE_DEPTH_DEF) begin
					res.status = ST_FULL;
				end else begin
					shadow_cells[shadow_fill] = item;
					shadow_fill++;
					res.status = ST_PUSHED;
				end
			end
			OP_POP: begin
				if (shadow_fill > 0)
					pos = 0;
			end
			OP_TAG: begin
				// Scan from the tail so that the oldest match wins.
				for (i = shadow_fill - 1; i >= 0; i--)
					if (shadow_cells[i].tag == item.tag)
						pos = i;
			end
			default: ;
		endcase
		// Report the removed entry and close the gap behind it.
		if (pos >= 0) begin
			res.status = ST_REMOVED;
			res.handle = shadow_cells[pos].handle;
			res.size   = shadow_cells[pos].size;
			res.tag    = shadow_cells[pos].tag;
			for (i = pos; i < shadow_fill - 1; i++)
				shadow_cells[i] = shadow_cells[i + 1];
			shadow_fill--;
		end
		return res;
	endfunction

	// Compare each strobed result with the oldest prediction, then record new transactions.
	always @(posedge clk) begin
		removal_t want;
		entry_t   item;
		if (done) begin
			if (awaited_results.size() == 0) begin
				$error("result with no transaction outstanding: status %0d handle %0h",
					status, out_handle);
				error_tally++;
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					error_tally++;
				end
				if (out_handle !== want.handle) begin
					$error("out_handle: expected %0h, actual %0h", want.handle, out_handle);
					error_tally++;
				end
				if (out_size !== want.size) begin
					$error("out_size: expected %0h, actual %0h", want.size, out_size);
					error_tally++;
				end
				if (out_tag !== want.tag) begin
					$error("out_tag: expected %0d, actual %0d", want.tag, out_tag);
					error_tally++;
				end
			end
		end
		if (arst_n && start && !busy) begin
			item.handle = data_handle;
			item.size   = item_size;
			item.tag    = match_tag;
			awaited_results.push_back(apply_to_shadow(operation, item));
		end
		outstanding <= awaited_results.size();
		mismatches  <= error_tally;
	end

endmodule

`default_nettype wire

### sim/tb_tagged_fifo_match_queue_top.sv
`default_nettype none

module tb_tagged_fifo_match_queue_top;
	import tfmq_pkg::*;

	// The one operation code that the block ignores.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// Cycles without any transaction before the run is declared hung.
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int PHASES = 15;
	localparam int PHASE_ITEMS = 30;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [1:0]         operation = OP_PUSH;
	logic [31:0]        data_handle = '0;
	logic [30:0]        item_size = '0;
	logic signed [31:0] match_tag = '0;
	logic               done;
	logic [1:0]         status;
	logic [31:0]        out_handle;
	logic [30:0]        out_size;
	logic signed [31:0] out_tag;
	int                 fault_count;
	int                 outstanding;
	int unsigned        quiet_cycles = 0;

	always #2 clk = ~clk;

	tagged_fifo_match_queue_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.data_handle (data_handle),
		.item_size   (item_size),
		.match_tag   (match_tag),
		.done        (done),
		.status      (status),
		.out_handle  (out_handle),
		.out_size    (out_size),
		.out_tag     (out_tag)
	);

	tfmq_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.data_handle (data_handle),
		.item_size   (item_size),
		.match_tag   (match_tag),
		.done        (done),
		.status      (status),
		.out_handle  (out_handle),
		.out_size    (out_size),
		.out_tag     (out_tag),
		.mismatches  (fault_count),
		.outstanding (outstanding)
	);

	// Watchdog: any transaction in either direction resets the count.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Presents one transaction and returns at the edge that takes it.
	task automatic send_item(input logic [1:0] op, input logic [31:0] handle,
			input logic [30:0] size, input logic signed [31:0] tag);
		start       <= 1'b1;
		operation   <= op;
		data_handle <= handle;
		item_size   <= size;
		match_tag   <= tag;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic rest_sender(input int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Holds off until every transaction sent so far has produced its result.
	task automatic await_drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// One random transaction; tags mostly come from a small pool so that tagged pops hit.
	task automatic random_item(input int unsigned push_pct);
		int unsigned        pick;
		logic [1:0]         op;
		logic [31:0]        handle;
		logic [30:0]        size;
		logic signed [31:0] tag;
		pick = $urandom_range(0, 99);
		if (pick < push_pct)
			op = OP_PUSH;
		else if (pick < push_pct + (96 - push_pct) / 2)
			op = OP_POP;
		else if (pick < 96)
			op = OP_TAG;
		else
			op = OP_UNUSED;
		case ($urandom_range(0, 19))
			0: handle = '0;
			1: handle = '1;
			default: handle = $urandom;
		endcase
		case ($urandom_range(0, 19))
			0: size = '0;
			1: size = '1;
			default: size = 31'($urandom);
		endcase
		if ($urandom_range(0, 3) != 0)
			tag = $signed(32'($urandom_range(0, 7))) - 32'sd3;
		else
			tag = $urandom;
		send_item(op, handle, size, tag);
	endtask

	initial begin
		int unsigned push_pct;
		int unsigned idle_pct;
		int          phase;
		int          k;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: operations on an empty queue.
		send_item(OP_POP, $urandom, 31'($urandom), $urandom);
		send_item(OP_TAG, $urandom, 31'($urandom), 32'sd0);
		send_item(OP_UNUSED, $urandom, 31'($urandom), $urandom);

		// Fill to the brim with field extremes at the head and repeated tags behind them.
		send_item(OP_PUSH, 32'h0, 31'h0, 32'sh8000_0000);
		send_item(OP_PUSH, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF);
		for (k = 2; k < QUEUE_DEPTH_DEF; k++)
			send_item(OP_PUSH, $urandom, 31'($urandom),
				(k == QUEUE_DEPTH_DEF - 1) ? 32'sd777 : 32'(k % 4));
		send_item(OP_PUSH, $urandom, 31'($urandom), $urandom);

		// Tagged pops at the head, among duplicates, at the tail and with no match.
		send_item(OP_TAG, $urandom, 31'($urandom), 32'sh8000_0000);
		send_item(OP_TAG, $urandom, 31'($urandom), 32'sd2);
		send_item(OP_TAG, $urandom, 31'($urandom), 32'sd777);
		send_item(OP_TAG, $urandom, 31'($urandom), 32'sd99);
		send_item(OP_UNUSED, $urandom, 31'($urandom), $urandom);
		send_item(OP_POP, $urandom, 31'($urandom), $urandom);
		await_drain();

		// Random phases, each with its own mix of pushes and its own idling.
		for (phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 2))
				0: push_pct = 25;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 25;
				default: idle_pct = 60;
			endcase
			if (phase >= PHASES - 2)
				idle_pct = 0;
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 99) < idle_pct)
					rest_sender($urandom_range(1, 9));
				random_item(push_pct);
			end
			// The closing phases run without any pause.
			if (phase == PHASES / 2 || (phase < PHASES - 2 && $urandom_range(0, 3) == 0))
				await_drain();
		end

		// Let the last results through, then give the verdict.
		await_drain();
		repeat (4) @(posedge clk);
		if (fault_count == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
